// ===== src/lms_pkg.sv =====
// Package for the local maximum search block: sizes, command and register
// codes, controller states, point struct, the shift table and mask addressing.
// No dependencies.
package lms_pkg;

  localparam int NUM_ORIENT = 16;
  localparam int MAX_ROWS   = 128;
  localparam int MAX_COLS   = 128;
  localparam int MAX_HALF   = 8;
  localparam int WIN_SIDE   = 4 * MAX_HALF + 1;

  localparam int O_W       = $clog2(NUM_ORIENT);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int MAP_AW    = O_W + ROW_W + COL_W;
  localparam int MAP_DEPTH = NUM_ORIENT * MAX_ROWS * MAX_COLS;
  localparam int MASK_DEPTH = NUM_ORIENT * NUM_ORIENT * WIN_SIDE * WIN_SIDE;
  localparam int MASK_AW   = $clog2(MASK_DEPTH);

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_MASK    = 3'd1,
    CMD_SEARCH  = 3'd2,
    CMD_INHIBIT = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_ROWS  = 3'd0,
    CFG_COLS  = 3'd1,
    CFG_HALF  = 3'd2,
    CFG_NRNG  = 3'd3,
    CFG_ORNG  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_SDRAIN,
    ST_INHIBIT,
    ST_IDRAIN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic               inb;
  } lms_pt_t;

  // floor(m*cos(r*pi/16) + 1/2) for m = 0..7, 3-bit fields listed m = 7 down to 0
  function automatic logic [2:0] rnd_step(input logic [3:0] row, input logic [2:0] mag);
    logic [23:0] vec;
    case (row)
      4'd0:    vec = {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
      4'd1:    vec = {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
      4'd2:    vec = {3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
      4'd3:    vec = {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0};
      4'd4:    vec = {3'd5, 3'd4, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0};
      4'd5:    vec = {3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1, 3'd0};
      4'd6:    vec = {3'd3, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd0, 3'd0};
      4'd7:    vec = {3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0};
      default: vec = '0;
    endcase
    return vec[3*mag +: 3];
  endfunction

  // ((pair*33 + ox)*33 + oy), offsets already biased to 0..32
  function automatic logic [MASK_AW-1:0] mask_addr(input logic [7:0] pair,
                                                    input logic [5:0] ox,
                                                    input logic [5:0] oy);
    logic [13:0] t1;
    t1 = {1'b0, pair, 5'b0} + {6'b0, pair} + {8'b0, ox};
    return {t1, 5'b0} + {5'b0, t1} + {13'b0, oy};
  endfunction

endpackage

// ===== src/lms_in_if.sv =====
// Request channel of the local maximum search block.
// Depends on nothing.
interface lms_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic [3:0]        orient;
  logic [3:0]        other_orient;
  logic signed [9:0] pos_x;
  logic signed [9:0] pos_y;
  logic signed [5:0] offset_x;
  logic signed [5:0] offset_y;
  logic signed [15:0] sample;
  logic              keep;

  modport source(output valid, cmd, orient, other_orient, pos_x, pos_y, offset_x,
                 offset_y, sample, keep, input ready);
  modport sink(input valid, cmd, orient, other_orient, pos_x, pos_y, offset_x,
               offset_y, sample, keep, output ready);
endinterface

// ===== src/lms_out_if.sv =====
// Result channel of the local maximum search block.
// Depends on nothing.
interface lms_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic signed [9:0]  best_x;
  logic signed [9:0]  best_y;
  logic [3:0]         best_orient;
  logic signed [3:0]  shift_step;
  logic signed [2:0]  orient_offset;
  logic               found;
  logic               error;

  modport source(output valid, value, best_x, best_y, best_orient, shift_step,
                 orient_offset, found, error, input ready);
  modport sink(input valid, value, best_x, best_y, best_orient, shift_step,
               orient_offset, found, error, output ready);
endinterface

// ===== src/lms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== src/lms_trig.sv =====
// Point generator: shifts a position along the normal of an orientation by
// a signed step count, using the rounded cos/sin table, and checks it against the image.
// Depends on lms_pkg.
module lms_trig (
  input  logic [3:0]        orient,
  input  logic signed [3:0] step,
  input  logic signed [9:0] pos_x,
  input  logic signed [9:0] pos_y,
  input  logic [7:0]        rows,
  input  logic [7:0]        cols,
  output lms_pkg::lms_pt_t  pt
);
  import lms_pkg::*;

  logic [3:0]        rc, rs, smag;
  logic              cneg, sneg;
  logic [2:0]        tc, ts;
  logic signed [4:0] dx, dy;

  always_comb begin
    sneg = step[3];
    smag = sneg ? 4'(-step) : step;
    cneg = (orient > 4'd8);
    rc   = cneg ? 4'(5'd16 - {1'b0, orient}) : orient;
    rs   = cneg ? 4'(orient - 4'd8) : 4'(4'd8 - orient);
    tc   = rnd_step(rc, smag[2:0]);
    ts   = rnd_step(rs, smag[2:0]);
    dx   = (cneg ^ sneg) ? -$signed({2'b0, tc}) : $signed({2'b0, tc});
    dy   = sneg ? -$signed({2'b0, ts}) : $signed({2'b0, ts});
    pt.x = $signed({pos_x[9], pos_x}) + $signed({{6{dx[4]}}, dx});
    pt.y = $signed({pos_y[9], pos_y}) + $signed({{6{dy[4]}}, dy});
    pt.inb = (pt.x >= 11'sd1) && (pt.x <= $signed({3'b0, rows})) &&
             (pt.y >= 11'sd1) && (pt.y <= $signed({3'b0, cols}));
  end
endmodule

// ===== src/local_max_search_with_inhibition.sv =====
// Top level of the local maximum search block: config registers, sequencer,
// response map and mask memories, result register.
// Depends on lms_pkg, lms_in_if, lms_out_if, lms_ram, lms_trig.
//
// Usage: requests arrive on in_req (valid/ready), one result per request
// leaves on out_rsp (valid/ready). Config is written through cfg_we,
// cfg_index and cfg_wdata while the block is idle.
// Requests are taken one at a time; in_req.ready is high only while the
// sequencer is idle. States from accept to result valid:
//   load sample, load mask bit, unknown command: response
//   read sample: read, response
//   search: at most (2*normal_range+1)*(2*orient_range+1) points, one map read
//     a cycle through the map memory's single read port; an out-of-image shift
//     issues no read and skips its orientation offsets; then drain, response
//   inhibit: 16 orientations by the clipped window (up to 16*33*33 points), one
//     mask read and at most one map write a cycle; drain, response (empty window: response)
// The result register frees the sequencer once loaded, so the next request
// can be accepted while the result waits; if the receiver stalls with a
// result pending, the following result holds in the sequencer.
// Reset (synchronous, rst_n low) clears the sequencer and the result valid
// and loads config defaults; memory contents are undefined until written.
module local_max_search_with_inhibition (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  lms_in_if.sink     in_req,
  lms_out_if.source  out_rsp
);
  import lms_pkg::*;

  // config
  logic [7:0] rows_r, cols_r;
  logic [3:0] half_r;
  logic [2:0] nrng_r;
  logic [1:0] orng_r;
  logic [7:0] rows_eff, cols_eff;
  logic [4:0] h2;

  state_t state_r, state_nxt;

  // item
  logic [3:0]        orient_r;
  logic signed [9:0] pos_x_r, pos_y_r;

  // loop counters
  logic signed [3:0]  l_r, l_nxt;
  logic signed [2:0]  de_r, de_nxt;
  logic [3:0]         io_r, io_nxt;
  logic signed [10:0] ix_r, ix_nxt, iy_r, iy_nxt;
  logic signed [10:0] x0_r, x9_r, y0_r, y9_r;

  // result under construction
  logic signed [15:0] val_r, val_nxt;
  logic signed [9:0]  bx_r, bx_nxt, by_r, by_nxt;
  logic [3:0]         bo_r, bo_nxt;
  logic signed [3:0]  step_r, step_nxt;
  logic signed [2:0]  ooff_r, ooff_nxt;
  logic               found_r, found_nxt, err_r, err_nxt;

  // search read in flight
  logic               tv_r, tv_nxt;
  logic signed [9:0]  tx_r, ty_r;
  logic [3:0]         td_r;
  logic signed [3:0]  tl_r;
  logic signed [2:0]  tde_r;

  // inhibit mask read in flight
  logic               iv_r, iv_nxt;
  logic [MAP_AW-1:0]  iaddr_r;

  // result register
  logic               out_valid_r;
  logic signed [15:0] o_val_r;
  logic signed [9:0]  o_bx_r, o_by_r;
  logic [3:0]         o_bo_r;
  logic signed [3:0]  o_step_r;
  logic signed [2:0]  o_ooff_r;
  logic               o_found_r, o_err_r;
  logic               load_out;

  // memories
  logic               map_we, map_re, mask_we, mask_re;
  logic [MAP_AW-1:0]  map_waddr, map_raddr;
  logic [15:0]        map_wdata, map_rdata;
  logic [MASK_AW-1:0] mask_waddr, mask_raddr;
  logic               mask_rdata;

  lms_pt_t            pt;
  logic [3:0]         d_orient;
  logic               accept;
  logic signed [10:0] ax, ay, cx0, cx9, cy0, cy9;
  logic               req_inb, mask_ok;
  logic signed [10:0] rx1, ry1;

  lms_ram #(.WIDTH(16), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .re(map_re), .raddr(map_raddr), .rdata(map_rdata)
  );

  lms_ram #(.WIDTH(1), .DEPTH(MASK_DEPTH)) u_mask (
    .clk(clk), .we(mask_we), .waddr(mask_waddr), .wdata(in_req.keep),
    .re(mask_re), .raddr(mask_raddr), .rdata(mask_rdata)
  );

  lms_trig u_trig (
    .orient(orient_r), .step(l_r), .pos_x(pos_x_r), .pos_y(pos_y_r),
    .rows(rows_eff), .cols(cols_eff), .pt(pt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 8'd128;
      cols_r <= 8'd128;
      half_r <= 4'd4;
      nrng_r <= 3'd3;
      orng_r <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_r <= cfg_wdata;
        CFG_COLS: cols_r <= cfg_wdata;
        CFG_HALF: half_r <= cfg_wdata[3:0];
        CFG_NRNG: nrng_r <= cfg_wdata[2:0];
        CFG_ORNG: orng_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = (rows_r > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : rows_r;
    cols_eff = (cols_r > 8'(MAX_COLS)) ? 8'(MAX_COLS) : cols_r;
    h2       = (half_r > 4'(MAX_HALF)) ? 5'(2 * MAX_HALF) : {half_r, 1'b0};
    accept   = in_req.valid && in_req.ready;
    ax       = $signed({in_req.pos_x[9], in_req.pos_x});
    ay       = $signed({in_req.pos_y[9], in_req.pos_y});
    req_inb  = (ax >= 11'sd1) && (ax <= $signed({3'b0, rows_eff})) &&
               (ay >= 11'sd1) && (ay <= $signed({3'b0, cols_eff}));
    mask_ok  = (in_req.offset_x >= -6'sd16) && (in_req.offset_x <= 6'sd16) &&
               (in_req.offset_y >= -6'sd16) && (in_req.offset_y <= 6'sd16);
    // clipped inhibit window
    cx0 = ax - $signed({6'b0, h2});
    cx0 = (cx0 > 11'sd1) ? cx0 : 11'sd1;
    cx9 = ax + $signed({6'b0, h2});
    cx9 = (cx9 < $signed({3'b0, rows_eff})) ? cx9 : $signed({3'b0, rows_eff});
    cy0 = ay - $signed({6'b0, h2});
    cy0 = (cy0 > 11'sd1) ? cy0 : 11'sd1;
    cy9 = ay + $signed({6'b0, h2});
    cy9 = (cy9 < $signed({3'b0, cols_eff})) ? cy9 : $signed({3'b0, cols_eff});
    d_orient = orient_r + {{1{de_r[2]}}, de_r};
    rx1 = ax - 11'sd1;
    ry1 = ay - 11'sd1;
  end

  assign in_req.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tv_r    <= 1'b0;
      iv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tv_r    <= tv_nxt;
      iv_r    <= iv_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    l_nxt      = l_r;
    de_nxt     = de_r;
    io_nxt     = io_r;
    ix_nxt     = ix_r;
    iy_nxt     = iy_r;
    val_nxt    = val_r;
    bx_nxt     = bx_r;
    by_nxt     = by_r;
    bo_nxt     = bo_r;
    step_nxt   = step_r;
    ooff_nxt   = ooff_r;
    found_nxt  = found_r;
    err_nxt    = err_r;
    tv_nxt     = 1'b0;
    iv_nxt     = 1'b0;
    load_out   = 1'b0;
    map_we     = 1'b0;
    map_waddr  = iaddr_r;
    map_wdata  = '0;
    map_re     = 1'b0;
    map_raddr  = {d_orient, pt.x[ROW_W-1:0] - 1'b1, pt.y[COL_W-1:0] - 1'b1};
    mask_we    = 1'b0;
    mask_waddr = mask_addr({in_req.orient, in_req.other_orient},
                           6'(in_req.offset_x + 6'sd16), 6'(in_req.offset_y + 6'sd16));
    mask_re    = 1'b0;
    mask_raddr = mask_addr({orient_r, io_r},
                           6'(ix_r - $signed({pos_x_r[9], pos_x_r}) + 11'sd16),
                           6'(iy_r - $signed({pos_y_r[9], pos_y_r}) + 11'sd16));

    // fold in the read that came back this cycle
    if (tv_r && (!found_r || $signed(map_rdata) > val_r)) begin
      found_nxt = 1'b1;
      val_nxt   = $signed(map_rdata);
      bx_nxt    = tx_r;
      by_nxt    = ty_r;
      bo_nxt    = td_r;
      step_nxt  = tl_r;
      ooff_nxt  = tde_r;
    end
    // suppress where the mask bit is clear
    if (iv_r && !mask_rdata) begin
      map_we = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt   = '0;
          bx_nxt    = '0;
          by_nxt    = '0;
          bo_nxt    = '0;
          step_nxt  = '0;
          ooff_nxt  = '0;
          found_nxt = 1'b0;
          err_nxt   = 1'b0;
          l_nxt     = -$signed({1'b0, nrng_r});
          de_nxt    = -$signed({1'b0, orng_r});
          io_nxt    = '0;
          ix_nxt    = cx0;
          iy_nxt    = cy0;
          state_nxt = ST_RESP;
          case (in_req.cmd)
            CMD_LOAD: begin
              if (req_inb) begin
                map_we    = 1'b1;
                map_waddr = {in_req.orient, rx1[ROW_W-1:0], ry1[COL_W-1:0]};
                map_wdata = in_req.sample;
              end else begin
                err_nxt = 1'b1;
              end
            end
            CMD_MASK: begin
              if (mask_ok) begin
                mask_we = 1'b1;
              end else begin
                err_nxt = 1'b1;
              end
            end
            CMD_SEARCH: begin
              val_nxt   = -16'sd32768;
              bx_nxt    = in_req.pos_x;
              by_nxt    = in_req.pos_y;
              bo_nxt    = in_req.orient;
              state_nxt = ST_SEARCH;
            end
            CMD_INHIBIT: begin
              if ((cx0 <= cx9) && (cy0 <= cy9)) begin
                state_nxt = ST_INHIBIT;
              end
            end
            CMD_READ: begin
              if (req_inb) begin
                map_re    = 1'b1;
                map_raddr = {in_req.orient, rx1[ROW_W-1:0], ry1[COL_W-1:0]};
                state_nxt = ST_READ;
              end else begin
                err_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        val_nxt   = $signed(map_rdata);
        state_nxt = ST_RESP;
      end
      ST_SEARCH: begin
        if (pt.inb) begin
          map_re = 1'b1;
          tv_nxt = 1'b1;
        end
        if (!pt.inb || (de_r == $signed({1'b0, orng_r}))) begin
          if (l_r == $signed({1'b0, nrng_r})) begin
            state_nxt = ST_SDRAIN;
          end else begin
            l_nxt  = l_r + 4'sd1;
            de_nxt = -$signed({1'b0, orng_r});
          end
        end else begin
          de_nxt = de_r + 3'sd1;
        end
      end
      ST_SDRAIN: begin
        state_nxt = ST_RESP;
      end
      ST_INHIBIT: begin
        mask_re = 1'b1;
        iv_nxt  = 1'b1;
        if (iy_r == y9_r) begin
          iy_nxt = y0_r;
          if (ix_r == x9_r) begin
            ix_nxt = x0_r;
            if (io_r == 4'(NUM_ORIENT - 1)) begin
              state_nxt = ST_IDRAIN;
            end else begin
              io_nxt = io_r + 4'd1;
            end
          end else begin
            ix_nxt = ix_r + 11'sd1;
          end
        end else begin
          iy_nxt = iy_r + 11'sd1;
        end
      end
      ST_IDRAIN: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    l_r     <= l_nxt;
    de_r    <= de_nxt;
    io_r    <= io_nxt;
    ix_r    <= ix_nxt;
    iy_r    <= iy_nxt;
    val_r   <= val_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    bo_r    <= bo_nxt;
    step_r  <= step_nxt;
    ooff_r  <= ooff_nxt;
    found_r <= found_nxt;
    err_r   <= err_nxt;
    tx_r    <= pt.x[9:0];
    ty_r    <= pt.y[9:0];
    td_r    <= d_orient;
    tl_r    <= l_r;
    tde_r   <= de_r;
    iaddr_r <= {io_r, 7'(ix_r - 11'sd1), 7'(iy_r - 11'sd1)};
    if (accept) begin
      orient_r <= in_req.orient;
      pos_x_r  <= in_req.pos_x;
      pos_y_r  <= in_req.pos_y;
      x0_r     <= cx0;
      x9_r     <= cx9;
      y0_r     <= cy0;
      y9_r     <= cy9;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_val_r   <= val_r;
      o_bx_r    <= bx_r;
      o_by_r    <= by_r;
      o_bo_r    <= bo_r;
      o_step_r  <= step_r;
      o_ooff_r  <= ooff_r;
      o_found_r <= found_r;
      o_err_r   <= err_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.value         = o_val_r;
  assign out_rsp.best_x        = o_bx_r;
  assign out_rsp.best_y        = o_by_r;
  assign out_rsp.best_orient   = o_bo_r;
  assign out_rsp.shift_step    = o_step_r;
  assign out_rsp.orient_offset = o_ooff_r;
  assign out_rsp.found         = o_found_r;
  assign out_rsp.error         = o_err_r;

`ifndef SYNTHESIS
  a_tag_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tv_r |-> (state_r == ST_SEARCH || state_r == ST_SDRAIN))
    else $error("search read in flight outside search");
  a_mask_in_inhibit: assert property (@(posedge clk) disable iff (!rst_n)
    iv_r |-> (state_r == ST_INHIBIT || state_r == ST_IDRAIN))
    else $error("mask read in flight outside inhibit");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (l_r <= $signed({1'b0, nrng_r})))
    else $error("shift counter past normal range");
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_found_r) |-> (o_step_r == 4'sd0 && o_ooff_r == 3'sd0))
    else $error("offsets set without a maximum");
`endif
endmodule
